// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared types, codes and default sizes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TOTAL_LOG2_DEF = 10;
    localparam int ADDR_W         = 10;
    localparam int REQ_W          = 12;
    localparam int ORDER_W        = 4;
    localparam int STATUS_W       = 2;
    localparam int MAX_WANT       = 12;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] free_address;
    } bba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [ORDER_W-1:0]  order;
        logic [STATUS_W-1:0] status;
    } bba_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_ROOT,
        S_A_PICK,
        S_D_RD,
        S_D_CHK,
        S_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_CHK,
        S_M_CLR,
        S_UP_W,
        S_UP_R,
        S_FIN
    } bba_state_t;

endpackage

// ===== hdl/buddy_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of an arena in a buddy scheme.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel as valid/ready transactions: allocate a
// block of request_size units, or free the block at free_address. Each
// request gives one result transaction on the m_ channel with the address,
// the order and a status (ok, out of memory, bad free).
// Every tree node of the arena holds a mask of the orders that are free in
// its subtree, in one RAM of 2^(TOTAL_LOG2+1) words; a second RAM holds the
// order of each allocated block. An allocation walks down the tree to the
// lowest free block of the smallest fitting order, writes the split halves
// and walks back up to the root. A free merges upwards and then walks up the
// same way. Requests are handled one at a time: the next request is taken
// only after the result of the last has moved into the output register.
// After reset a clearing pass over all 2^(TOTAL_LOG2+1) map words initialises
// both RAMs, during which no request is accepted. A finished result is held
// in an output register; one more request is taken while it waits, and the
// block then holds its next result until the receiver takes the first.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit #(
    parameter int TOTAL_LOG2 = bba_pkg::TOTAL_LOG2_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bba_pkg::bba_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bba_pkg::bba_rsp_t m_data
);

    import bba_pkg::*;

    localparam int L     = TOTAL_LOG2;
    localparam int MW    = L + 1;
    localparam int IW    = L + 1;
    localparam int LW    = $clog2(((L > MAX_WANT) ? L : MAX_WANT) + 1);
    localparam int TW    = ORDER_W + 1;
    localparam logic [LW-1:0] LTOP = LW'(L);

    bba_state_t      state_reg, state_next;
    logic [IW-1:0]   clr_reg, clr_next;
    logic            op_reg, op_next;
    logic [ADDR_W-1:0] fa_reg, fa_next;
    logic [LW-1:0]   want_reg, want_next;
    logic [LW-1:0]   k_reg, k_next;
    logic [LW-1:0]   lvl_reg, lvl_next;
    logic [L-1:0]    addr_reg, addr_next;
    logic [MW-1:0]   c_reg, c_next;
    bba_rsp_t        res_reg, res_next;
    bba_rsp_t        m_data_reg, m_data_next;
    logic            m_valid_reg, m_valid_next;

    logic            map_we;
    logic [IW-1:0]   map_wa, map_ra;
    logic [MW-1:0]   map_wd, map_rd;
    logic            tbl_we;
    logic [L-1:0]    tbl_wa, tbl_ra;
    logic [TW-1:0]   tbl_wd, tbl_rd;

    logic [REQ_W:0]  req_ext;
    logic [LW-1:0]   want_calc;
    logic [MW-1:0]   avail;
    logic [LW-1:0]   low_bit;
    logic [L-1:0]    step_bit;
    logic [L-1:0]    down_bit;
    logic            fa_out;

    function automatic logic [IW-1:0] node_idx(input logic [LW-1:0] lvl,
                                               input logic [L-1:0] a);
        node_idx = (IW'(1) << (LTOP - lvl)) | (IW'(a) >> lvl);
    endfunction

    function automatic logic [ADDR_W-1:0] out_addr(input logic [L-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        out_addr = w[ADDR_W-1:0];
    endfunction

    bba_ram #(.WIDTH(MW), .DEPTH(2 ** IW)) u_map_ram (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_wa),
        .wr_data (map_wd),
        .rd_addr (map_ra),
        .rd_data (map_rd)
    );

    bba_ram #(.WIDTH(TW), .DEPTH(2 ** L)) u_tbl_ram (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_wa),
        .wr_data (tbl_wd),
        .rd_addr (tbl_ra),
        .rd_data (tbl_rd)
    );

    always_comb begin
        req_ext   = (s_data.request_size == '0) ? (REQ_W + 1)'(1)
                                                : {1'b0, s_data.request_size};
        want_calc = LW'(MAX_WANT);
        for (int i = MAX_WANT; i >= 0; i--) begin
            if (req_ext <= ((REQ_W + 1)'(1) << i)) begin
                want_calc = LW'(i);
            end
        end
        avail   = map_rd & ~((MW'(1) << want_reg) - MW'(1));
        low_bit = '0;
        for (int i = L; i >= 0; i--) begin
            if (avail[i]) begin
                low_bit = LW'(i);
            end
        end
        step_bit = L'(1) << lvl_reg;
        down_bit = L'(1) << (lvl_reg - LW'(1));
        fa_out   = (32'(fa_reg) >= (32'd1 << L));
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        fa_next      = fa_reg;
        want_next    = want_reg;
        k_next       = k_reg;
        lvl_next     = lvl_reg;
        addr_next    = addr_reg;
        c_next       = c_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + IW'(1);
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_data.operation;
                    fa_next   = s_data.free_address;
                    want_next = want_calc;
                    if (s_data.operation == OP_FREE) begin
                        state_next = S_F_RD;
                    end else if (want_calc > LTOP) begin
                        res_next   = '{address: '0, order: '0, status: ST_NO_MEM};
                        state_next = S_FIN;
                    end else begin
                        state_next = S_A_ROOT;
                    end
                end
            end
            S_A_ROOT: begin
                state_next = S_A_PICK;
            end
            S_A_PICK: begin
                lvl_next  = LTOP;
                addr_next = '0;
                k_next    = low_bit;
                c_next    = '0;
                if (avail == '0) begin
                    res_next   = '{address: '0, order: '0, status: ST_NO_MEM};
                    state_next = S_FIN;
                end else if (low_bit != LTOP) begin
                    state_next = S_D_RD;
                end else if (LTOP > want_reg) begin
                    state_next = S_SPLIT;
                end else begin
                    state_next = S_UP_W;
                end
            end
            S_D_RD: begin
                state_next = S_D_CHK;
            end
            S_D_CHK: begin
                lvl_next = lvl_reg - LW'(1);
                if ((map_rd & (MW'(1) << k_reg)) == '0) begin
                    addr_next = addr_reg | down_bit;
                end
                if (lvl_reg - LW'(1) != k_reg) begin
                    state_next = S_D_RD;
                end else if (k_reg > want_reg) begin
                    state_next = S_SPLIT;
                end else begin
                    state_next = S_UP_W;
                end
            end
            S_SPLIT: begin
                lvl_next = lvl_reg - LW'(1);
                if (lvl_reg - LW'(1) == want_reg) begin
                    state_next = S_UP_W;
                end
            end
            S_F_RD: begin
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                addr_next = L'(fa_reg);
                lvl_next  = LW'(tbl_rd[ORDER_W-1:0]);
                res_next  = '{address: fa_reg, order: tbl_rd[ORDER_W-1:0], status: ST_OK};
                c_next    = MW'(1) << tbl_rd[ORDER_W-1:0];
                if (fa_out || !tbl_rd[ORDER_W]) begin
                    res_next   = '{address: fa_reg, order: '0, status: ST_BAD_FREE};
                    state_next = S_FIN;
                end else if (LW'(tbl_rd[ORDER_W-1:0]) == LTOP) begin
                    state_next = S_UP_W;
                end else begin
                    state_next = S_M_RD;
                end
            end
            S_M_RD: begin
                state_next = S_M_CHK;
            end
            S_M_CHK: begin
                if ((map_rd & (MW'(1) << lvl_reg)) != '0) begin
                    state_next = S_M_CLR;
                end else begin
                    c_next     = MW'(1) << lvl_reg;
                    state_next = S_UP_W;
                end
            end
            S_M_CLR: begin
                addr_next = addr_reg & ~step_bit;
                lvl_next  = lvl_reg + LW'(1);
                c_next    = MW'(1) << (lvl_reg + LW'(1));
                if (lvl_reg + LW'(1) == LTOP) begin
                    state_next = S_UP_W;
                end else begin
                    state_next = S_M_RD;
                end
            end
            S_UP_W: begin
                if (lvl_reg == LTOP) begin
                    if (op_reg == OP_ALLOC) begin
                        res_next = '{address: out_addr(addr_reg),
                                     order: ORDER_W'(want_reg), status: ST_OK};
                    end
                    state_next = S_FIN;
                end else begin
                    state_next = S_UP_R;
                end
            end
            S_UP_R: begin
                c_next     = c_reg | map_rd;
                lvl_next   = lvl_reg + LW'(1);
                state_next = S_UP_W;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        map_we = 1'b0;
        map_wa = node_idx(lvl_reg, addr_reg);
        map_wd = c_reg;
        map_ra = node_idx(lvl_reg, addr_reg ^ step_bit);
        tbl_we = 1'b0;
        tbl_wa = L'(fa_reg);
        tbl_wd = '0;
        tbl_ra = L'(fa_reg);
        s_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = clr_reg;
                map_wd = (clr_reg == IW'(1)) ? (MW'(1) << L) : '0;
                tbl_we = !clr_reg[L];
                tbl_wa = clr_reg[L-1:0];
            end
            S_A_ROOT: begin
                map_ra = IW'(1);
            end
            S_D_RD: begin
                map_ra = node_idx(lvl_reg - LW'(1), addr_reg);
            end
            S_SPLIT: begin
                map_we = 1'b1;
                map_wa = node_idx(lvl_reg - LW'(1), addr_reg | down_bit);
                map_wd = MW'(1) << (lvl_reg - LW'(1));
            end
            S_F_CHK: begin
                tbl_we = !fa_out && tbl_rd[ORDER_W];
            end
            S_M_CHK: begin
                map_we = (map_rd & (MW'(1) << lvl_reg)) != '0;
                map_wa = node_idx(lvl_reg, addr_reg ^ step_bit);
                map_wd = '0;
            end
            S_M_CLR: begin
                map_we = 1'b1;
                map_wd = '0;
            end
            S_UP_W: begin
                map_we = 1'b1;
                if (lvl_reg == LTOP && op_reg == OP_ALLOC) begin
                    tbl_we = 1'b1;
                    tbl_wa = addr_reg;
                    tbl_wd = {1'b1, ORDER_W'(want_reg)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        fa_reg     <= fa_next;
        want_reg   <= want_next;
        k_reg      <= k_next;
        lvl_reg    <= lvl_next;
        addr_reg   <= addr_next;
        c_reg      <= c_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_desc_above_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_D_CHK) |-> (lvl_reg > k_reg && k_reg >= want_reg))
        else $error("descent passed the chosen order");

    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP_W && lvl_reg == LTOP) |=> (state_reg == S_FIN))
        else $error("root write did not finish the request");

    a_ok_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_OK) |->
        ((32'(m_data.address) & ((32'd1 << m_data.order) - 32'd1)) == 32'd0))
        else $error("result block not aligned to its order");

    a_load_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && m_valid_reg && !m_ready) |=> (state_reg == S_FIN))
        else $error("result overwritten while the receiver stalls");

endmodule

// ===== hdl/bba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free transactions into the allocator, predicts every
// result with a behavioural buddy model and compares results field by field.
// ----------------------------------------------------------------------------
module tb;
    import bba_pkg::*;

    localparam int LOG2  = TOTAL_LOG2_DEF;
    localparam int UNITS = 1 << LOG2;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    bba_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    bba_rsp_t m_data;

    buddy_block_allocator_unit #(.TOTAL_LOG2(LOG2)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bba_req_t pending_reqs[$];
    bba_rsp_t expected_rsps[$];
    bit       block_free[2*UNITS];
    bit       alloc_valid[UNITS];
    int       alloc_order[UNITS];
    int       live_addrs[$];
    int       errors;
    int       n_sent;
    int       n_checked;
    int       n_ok;
    int       n_nomem;
    int       n_badfree;
    int       src_gap;
    int       snk_gap;
    int       hold_off;
    bit       quiet;
    bit       stim_done;

    function automatic int node_of(int k, int a);
        return (1 << (LOG2 - k)) + (a >> k);
    endfunction

    function automatic bba_rsp_t predict_buddy(bba_req_t r);
        bba_rsp_t p;
        int       want;
        int       lvl;
        int       addr;
        int       cnt;
        int       cur;
        int       req;
        bit       hit;
        p    = '0;
        hit  = 0;
        addr = 0;
        lvl  = 0;
        if (r.operation == OP_ALLOC) begin
            req  = (r.request_size == 0) ? 1 : int'(r.request_size);
            want = 0;
            while ((1 << want) < req) want++;
            if (want <= LOG2) begin
                for (int k = want; k <= LOG2 && !hit; k++) begin
                    cnt = 1 << (LOG2 - k);
                    for (int j = 0; j < cnt && !hit; j++) begin
                        if (block_free[cnt + j]) begin
                            hit = 1;
                            addr = j << k;
                            lvl = k;
                            block_free[cnt + j] = 0;
                        end
                    end
                end
            end
            if (!hit) begin
                p.status = ST_NO_MEM;
            end else begin
                while (lvl > want) begin
                    lvl--;
                    block_free[node_of(lvl, addr + (1 << lvl))] = 1;
                end
                alloc_valid[addr] = 1;
                alloc_order[addr] = want;
                p.address = addr[ADDR_W-1:0];
                p.order   = want[ORDER_W-1:0];
                p.status  = ST_OK;
            end
        end else begin
            addr = int'(r.free_address);
            p.address = r.free_address;
            if (addr >= UNITS || !alloc_valid[addr]) begin
                p.status = ST_BAD_FREE;
            end else begin
                lvl = alloc_order[addr];
                p.order = lvl[ORDER_W-1:0];
                p.status = ST_OK;
                alloc_valid[addr] = 0;
                cur = addr;
                while (lvl < LOG2 && block_free[node_of(lvl, cur ^ (1 << lvl))]) begin
                    block_free[node_of(lvl, cur ^ (1 << lvl))] = 0;
                    cur &= ~(1 << lvl);
                    lvl++;
                end
                block_free[node_of(lvl, cur)] = 1;
            end
        end
        return p;
    endfunction

    task automatic push_req(bit op, int sz, int fa);
        bba_req_t r;
        r.operation    = op;
        r.request_size = sz[REQ_W-1:0];
        r.free_address = fa[ADDR_W-1:0];
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Driver: prediction is made at acceptance so the model stays in order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_data  <= '0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsps.insert(expected_rsps.size(), predict_buddy(s_data));
                n_sent <= n_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 0;
                end else if (pending_reqs.size() > 0) begin
                    s_valid <= 1;
                    s_data  <= pending_reqs.pop_front();
                    if (!quiet && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 4);
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Monitor and sink back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            snk_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("result with no expectation waiting");
                    errors++;
                end else begin
                    bba_rsp_t e;
                    e = expected_rsps.pop_front();
                    n_checked++;
                    case (e.status)
                        ST_OK:     n_ok++;
                        ST_NO_MEM: n_nomem++;
                        default:   n_badfree++;
                    endcase
                    if (m_data.address !== e.address) begin
                        $error("address expected %0d actual %0d", e.address, m_data.address);
                        errors++;
                    end
                    if (m_data.order !== e.order) begin
                        $error("order expected %0d actual %0d", e.order, m_data.order);
                        errors++;
                    end
                    if (m_data.status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_data.status);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                m_ready  <= 0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    snk_gap <= $urandom_range(1, 4);
            end
        end
    end

    initial begin
        int  pick;
        int  idx;
        int  sz;
        int  wait_cycles;
        bit  op;
        aresetn   = 0;
        s_valid   = 0;
        s_data    = '0;
        m_ready   = 0;
        errors    = 0;
        n_sent    = 0;
        n_checked = 0;
        n_ok      = 0;
        n_nomem   = 0;
        n_badfree = 0;
        hold_off  = 0;
        quiet     = 0;
        stim_done = 0;
        foreach (block_free[i]) block_free[i] = 0;
        foreach (alloc_valid[i]) alloc_valid[i] = 0;
        block_free[1] = 1;
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // Directed: whole arena, over capacity, size zero, frees of all kinds.
        push_req(OP_ALLOC, 1024, 0);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_FREE, 4095, 0);
        push_req(OP_FREE, 0, 0);
        push_req(OP_ALLOC, 4095, 1023);
        push_req(OP_ALLOC, 1025, 0);
        push_req(OP_ALLOC, 0, 1023);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_ALLOC, 3, 0);
        push_req(OP_ALLOC, 512, 0);
        push_req(OP_FREE, 0, 1);
        push_req(OP_FREE, 0, 5);
        push_req(OP_FREE, 0, 1023);
        push_req(OP_FREE, 0, 0);
        push_req(OP_FREE, 0, 0);
        push_req(OP_FREE, 4095, 1);
        push_req(OP_FREE, 0, 4);
        push_req(OP_FREE, 0, 512);
        push_req(OP_ALLOC, 2048, 0);
        push_req(OP_ALLOC, 1024, 0);
        push_req(OP_FREE, 0, 0);

        // Long receiver hold-off while requests keep coming.
        wait (pending_reqs.size() == 0);
        for (int i = 0; i < 12; i++) push_req(OP_ALLOC, $urandom_range(1, 8), 0);
        hold_off = 300;
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        for (int i = 0; i < 16; i++) push_req(OP_FREE, 0, i * 16);
        for (int i = 0; i < 16; i++) push_req(OP_FREE, 0, i * 8);

        // Random part: free only addresses known to be live most of the time.
        for (int i = 0; i < 380; i++) begin
            if (i == 330) begin
                wait (pending_reqs.size() == 0);
                quiet = 1;
            end
            wait (pending_reqs.size() < 4);
            op   = $urandom_range(0, 99) < 50;
            pick = $urandom_range(0, 99);
            if (op == OP_ALLOC) begin
                if (pick < 70) sz = $urandom_range(0, 32);
                else if (pick < 90) sz = $urandom_range(0, 1024);
                else sz = $urandom_range(0, 4095);
                push_req(OP_ALLOC, sz, $urandom_range(0, 1023));
                wait (pending_reqs.size() == 0 && !s_valid && expected_rsps.size() == 0);
                live_addrs.delete();
                foreach (alloc_valid[a])
                    if (alloc_valid[a]) live_addrs.insert(live_addrs.size(), a);
            end else if (pick < 80 && live_addrs.size() > 0) begin
                idx = $urandom_range(0, live_addrs.size() - 1);
                push_req(OP_FREE, $urandom_range(0, 4095), live_addrs[idx]);
                live_addrs.delete(idx);
            end else begin
                push_req(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 1023));
            end
        end

        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_rsps.size() == 0);
        repeat (100) @(posedge aclk);
        $display("Checked %0d results: %0d ok, %0d out of memory, %0d bad free.",
                 n_checked, n_ok, n_nomem, n_badfree);
        $display("Stimulus covered splits, merges, double frees and a long output stall.");
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("buddy_block_allocator_unit test passed");
        end else begin
            $display("buddy_block_allocator_unit test failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("buddy_block_allocator_unit test failed");
        $finish;
    end

endmodule
